### sv/ihex_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and character helpers for the Intel HEX record encoder.
// Used by every module of the block except ihex_ram; depends on nothing else.

package ihex_pkg;

    localparam int RECORD_BYTES = 16;
    localparam int BUF_AW       = $clog2(RECORD_BYTES);
    localparam int CNT_W        = BUF_AW + 1;
    localparam int RAM_DEPTH    = 2 * RECORD_BYTES;
    localparam int RAM_AW       = $clog2(RAM_DEPTH);
    localparam int ADDR_W       = 16;
    localparam int EOF_LEN      = 12;
    localparam int EOF_IW       = $clog2(EOF_LEN);

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_F     = 8'h46;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [7:0] REC_TYPE_DATA = 8'h00;

    // One closed record waiting for the text sequencer
    typedef struct packed {
        logic              bank;
        logic [CNT_W-1:0]  count;
        logic [ADDR_W-1:0] offset;
        logic [7:0]        dsum;
        logic              last;
    } t_rec_desc;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_COLON,
        BK_LEN_H,
        BK_LEN_L,
        BK_AH_H,
        BK_AH_L,
        BK_AL_H,
        BK_AL_L,
        BK_TY_H,
        BK_TY_L,
        BK_DAT_H,
        BK_DAT_L,
        BK_CK_H,
        BK_CK_L,
        BK_LF,
        BK_EOF
    } t_bk_state;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] c;
        if (nib < 4'd10) begin
            c = CH_ZERO + {4'd0, nib};
        end else begin
            c = CH_A + {4'd0, nib} - 8'd10;
        end
        return c;
    endfunction

    // ":00000001FF" followed by a line feed
    function automatic logic [7:0] eof_char(input logic [EOF_IW-1:0] idx);
        logic [7:0] c;
        case (idx) inside
            4'd0:        c = CH_COLON;
            [4'd1:4'd7]: c = CH_ZERO;
            4'd8:        c = CH_ONE;
            4'd9, 4'd10: c = CH_F;
            default:     c = CH_LF;
        endcase
        return c;
    endfunction

endpackage

### sv/ihex_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.

module ihex_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### sv/ihex_front.sv
`timescale 1ns / 1ps
// Intake side: writes bytes into the open record bank and closes records.
// Depends on ihex_pkg.

module ihex_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [7:0]                 i_data,
    input  logic                       i_last,
    input  logic                       i_full,
    output logic                       o_push,
    output ihex_pkg::t_rec_desc        o_desc,
    output logic                       o_ram_we,
    output logic [ihex_pkg::RAM_AW-1:0] o_ram_waddr,
    output logic [7:0]                 o_ram_wdata
);

    logic                              r_bank;
    logic [ihex_pkg::BUF_AW-1:0]       r_fill;
    logic [ihex_pkg::ADDR_W-1:0]       r_offset;
    logic [7:0]                        r_sum;
    logic                              n_bank;
    logic [ihex_pkg::BUF_AW-1:0]       n_fill;
    logic [ihex_pkg::ADDR_W-1:0]       n_offset;
    logic [7:0]                        n_sum;
    logic                              w_acc;
    logic [ihex_pkg::CNT_W-1:0]        w_count;
    logic                              w_close;

    assign o_ready = !i_full;
    assign w_acc   = i_valid && o_ready;
    assign w_count = {1'b0, r_fill} + ihex_pkg::CNT_W'(1);
    assign w_close = (w_count == ihex_pkg::CNT_W'(ihex_pkg::RECORD_BYTES)) || i_last;

    assign o_ram_we    = w_acc;
    assign o_ram_waddr = {r_bank, r_fill};
    assign o_ram_wdata = i_data;

    assign o_push      = w_acc && w_close;
    assign o_desc.bank   = r_bank;
    assign o_desc.count  = w_count;
    assign o_desc.offset = r_offset;
    assign o_desc.dsum   = r_sum + i_data;
    assign o_desc.last   = i_last;

    always_comb begin
        n_bank   = r_bank;
        n_fill   = r_fill;
        n_offset = r_offset;
        n_sum    = r_sum;
        if (w_acc) begin
            if (w_close) begin
                // hand the bank over and start the next record in the other one
                n_bank   = !r_bank;
                n_fill   = '0;
                n_sum    = '0;
                n_offset = i_last ? '0
                                  : r_offset + {{(ihex_pkg::ADDR_W-ihex_pkg::CNT_W){1'b0}},
                                                w_count};
            end else begin
                n_fill = r_fill + ihex_pkg::BUF_AW'(1);
                n_sum  = r_sum + i_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank   <= 1'b0;
            r_fill   <= '0;
            r_offset <= '0;
            r_sum    <= '0;
        end else begin
            r_bank   <= n_bank;
            r_fill   <= n_fill;
            r_offset <= n_offset;
            r_sum    <= n_sum;
        end
    end

endmodule

### sv/ihex_queue.sv
`timescale 1ns / 1ps
// Two-entry queue of closed record descriptors, one per buffer bank.
// Depends on ihex_pkg.

module ihex_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  ihex_pkg::t_rec_desc  i_desc,
    input  logic                 i_pop,
    output ihex_pkg::t_rec_desc  o_head,
    output logic                 o_empty,
    output logic                 o_full
);

    ihex_pkg::t_rec_desc r_mem [2];
    logic                r_wp;
    logic                r_rp;
    logic [1:0]          r_cnt;

    assign o_head  = r_mem[r_rp];
    assign o_empty = (r_cnt == 2'd0);
    assign o_full  = (r_cnt == 2'd2);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

### sv/ihex_back.sv
`timescale 1ns / 1ps
// Text sequencer: turns one record descriptor plus its bank into HEX characters.
// Depends on ihex_pkg; reads the record bank through the shared RAM.

module ihex_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [ihex_pkg::ADDR_W-1:0] i_base,
    input  ihex_pkg::t_rec_desc         i_head,
    input  logic                        i_empty,
    output logic                        o_pop,
    output logic [ihex_pkg::RAM_AW-1:0] o_ram_raddr,
    input  logic [7:0]                  i_ram_rdata,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [7:0]                  o_char,
    output logic                        o_last
);

    ihex_pkg::t_bk_state               r_state;
    ihex_pkg::t_bk_state               n_state;
    logic [ihex_pkg::BUF_AW-1:0]       r_byte_idx;
    logic [ihex_pkg::BUF_AW-1:0]       n_byte_idx;
    logic [ihex_pkg::EOF_IW-1:0]       r_eof_idx;
    logic [ihex_pkg::EOF_IW-1:0]       n_eof_idx;
    logic [ihex_pkg::ADDR_W-1:0]       r_addr;
    logic [7:0]                        r_cks;
    logic                              r_out_valid;
    logic [7:0]                        r_out_char;
    logic                              r_out_last;
    logic                              w_adv;
    logic                              w_load;
    logic [7:0]                        w_char;
    logic                              w_char_last;
    logic                              w_start;
    logic [ihex_pkg::ADDR_W-1:0]       w_addr;
    logic [7:0]                        w_len;

    assign w_len  = {{(8-ihex_pkg::CNT_W){1'b0}}, i_head.count};
    assign w_addr = i_head.offset + i_base;
    assign w_adv  = (r_state != ihex_pkg::BK_IDLE) && (!r_out_valid || i_ready);

    // Next-index address keeps the registered read one step ahead
    assign o_ram_raddr = {i_head.bank, n_byte_idx};

    always_comb begin
        n_state     = r_state;
        n_byte_idx  = r_byte_idx;
        n_eof_idx   = r_eof_idx;
        w_load      = 1'b0;
        w_char      = ihex_pkg::CH_LF;
        w_char_last = 1'b0;
        w_start     = 1'b0;
        o_pop       = 1'b0;
        case (r_state)
            ihex_pkg::BK_IDLE: begin
                if (!i_empty) begin
                    w_start    = 1'b1;
                    n_byte_idx = '0;
                    n_eof_idx  = '0;
                    n_state    = ihex_pkg::BK_COLON;
                end
            end
            ihex_pkg::BK_COLON: begin
                w_char  = ihex_pkg::CH_COLON;
                n_state = ihex_pkg::BK_LEN_H;
            end
            ihex_pkg::BK_LEN_H: begin
                w_char  = ihex_pkg::hex_char(w_len[7:4]);
                n_state = ihex_pkg::BK_LEN_L;
            end
            ihex_pkg::BK_LEN_L: begin
                w_char  = ihex_pkg::hex_char(w_len[3:0]);
                n_state = ihex_pkg::BK_AH_H;
            end
            ihex_pkg::BK_AH_H: begin
                w_char  = ihex_pkg::hex_char(r_addr[15:12]);
                n_state = ihex_pkg::BK_AH_L;
            end
            ihex_pkg::BK_AH_L: begin
                w_char  = ihex_pkg::hex_char(r_addr[11:8]);
                n_state = ihex_pkg::BK_AL_H;
            end
            ihex_pkg::BK_AL_H: begin
                w_char  = ihex_pkg::hex_char(r_addr[7:4]);
                n_state = ihex_pkg::BK_AL_L;
            end
            ihex_pkg::BK_AL_L: begin
                w_char  = ihex_pkg::hex_char(r_addr[3:0]);
                n_state = ihex_pkg::BK_TY_H;
            end
            ihex_pkg::BK_TY_H: begin
                w_char  = ihex_pkg::hex_char(ihex_pkg::REC_TYPE_DATA[7:4]);
                n_state = ihex_pkg::BK_TY_L;
            end
            ihex_pkg::BK_TY_L: begin
                w_char  = ihex_pkg::hex_char(ihex_pkg::REC_TYPE_DATA[3:0]);
                n_state = ihex_pkg::BK_DAT_H;
            end
            ihex_pkg::BK_DAT_H: begin
                w_char  = ihex_pkg::hex_char(i_ram_rdata[7:4]);
                n_state = ihex_pkg::BK_DAT_L;
            end
            ihex_pkg::BK_DAT_L: begin
                w_char = ihex_pkg::hex_char(i_ram_rdata[3:0]);
                if (w_adv) begin
                    if (({1'b0, r_byte_idx} + ihex_pkg::CNT_W'(1)) == i_head.count) begin
                        n_state = ihex_pkg::BK_CK_H;
                    end else begin
                        n_byte_idx = r_byte_idx + ihex_pkg::BUF_AW'(1);
                        n_state    = ihex_pkg::BK_DAT_H;
                    end
                end
            end
            ihex_pkg::BK_CK_H: begin
                w_char  = ihex_pkg::hex_char(r_cks[7:4]);
                n_state = ihex_pkg::BK_CK_L;
            end
            ihex_pkg::BK_CK_L: begin
                w_char  = ihex_pkg::hex_char(r_cks[3:0]);
                n_state = ihex_pkg::BK_LF;
            end
            ihex_pkg::BK_LF: begin
                w_char = ihex_pkg::CH_LF;
                if (i_head.last) begin
                    n_state = ihex_pkg::BK_EOF;
                end else begin
                    w_char_last = 1'b1;
                    o_pop       = w_adv;
                    n_state     = ihex_pkg::BK_IDLE;
                end
            end
            ihex_pkg::BK_EOF: begin
                w_char = ihex_pkg::eof_char(r_eof_idx);
                if (r_eof_idx == ihex_pkg::EOF_IW'(ihex_pkg::EOF_LEN - 1)) begin
                    w_char_last = 1'b1;
                    o_pop       = w_adv;
                    n_state     = ihex_pkg::BK_IDLE;
                end else begin
                    n_eof_idx = r_eof_idx + ihex_pkg::EOF_IW'(1);
                end
            end
            default: begin
                n_state = ihex_pkg::BK_IDLE;
            end
        endcase
        // hold everything while the output word is stalled
        if (r_state != ihex_pkg::BK_IDLE) begin
            w_load = w_adv;
            if (!w_adv) begin
                n_state    = r_state;
                n_byte_idx = r_byte_idx;
                n_eof_idx  = r_eof_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ihex_pkg::BK_IDLE;
            r_byte_idx  <= '0;
            r_eof_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_byte_idx <= n_byte_idx;
            r_eof_idx  <= n_eof_idx;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_addr <= w_addr;
            r_cks  <= 8'd0 - (i_head.dsum + w_len + w_addr[15:8] + w_addr[7:0]);
        end
        if (w_load) begin
            r_out_char <= w_char;
            r_out_last <= w_char_last;
        end
    end

    assign o_valid = r_out_valid;
    assign o_char  = r_out_char;
    assign o_last  = r_out_last;

endmodule

### sv/intel_hex_record_encoder.sv
`timescale 1ns / 1ps
// Top level of the Intel HEX record encoder: intake, record queue, text sequencer.
// Depends on ihex_pkg, ihex_ram, ihex_front, ihex_queue and ihex_back.
//
//  Channel   Direction  Payload                                Handshake
//  s_axis    in         tdata[7:0] data_byte, tlast final_byte  tvalid/tready
//  m_axis    out        tdata[7:0] text_char, tlast run_end     tvalid/tready
//  cfg       in         i_cfg_wdata[15:0] base_address          i_cfg_we
//
//  Intake takes one byte per cycle while a record bank is free; two banks let one
//  record fill while the other prints. The sequencer sends one character per cycle while
//  m_axis is ready, with a setup step before each record, and the final record adds
//  12 characters of end-of-file text.
//  Reset is synchronous, active low, and clears control state only.
//  A stalled m_axis holds the output word; intake runs on until both banks are full.

module intel_hex_record_encoder (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [7:0]                  s_axis_tdata,   // [7:0] data_byte
    input  logic                        s_axis_tlast,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [7:0]                  m_axis_tdata,   // [7:0] text_char
    output logic                        m_axis_tlast,
    input  logic                        i_cfg_we,
    input  logic [ihex_pkg::ADDR_W-1:0] i_cfg_wdata
);

    logic [ihex_pkg::ADDR_W-1:0] r_base;
    ihex_pkg::t_rec_desc         w_push_desc;
    ihex_pkg::t_rec_desc         w_head;
    logic                        w_push;
    logic                        w_pop;
    logic                        w_empty;
    logic                        w_full;
    logic                        w_ram_we;
    logic [ihex_pkg::RAM_AW-1:0] w_ram_waddr;
    logic [7:0]                  w_ram_wdata;
    logic [ihex_pkg::RAM_AW-1:0] w_ram_raddr;
    logic [7:0]                  w_ram_rdata;

    // Base address register; read when a record starts printing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
        end else if (i_cfg_we) begin
            r_base <= i_cfg_wdata;
        end
    end

    ihex_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_data      (s_axis_tdata),
        .i_last      (s_axis_tlast),
        .i_full      (w_full),
        .o_push      (w_push),
        .o_desc      (w_push_desc),
        .o_ram_we    (w_ram_we),
        .o_ram_waddr (w_ram_waddr),
        .o_ram_wdata (w_ram_wdata)
    );

    // Two banks of record bytes
    ihex_ram #(
        .WIDTH (8),
        .DEPTH (ihex_pkg::RAM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    ihex_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_desc  (w_push_desc),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_empty (w_empty),
        .o_full  (w_full)
    );

    ihex_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_base      (r_base),
        .i_head      (w_head),
        .i_empty     (w_empty),
        .o_pop       (w_pop),
        .o_ram_raddr (w_ram_raddr),
        .i_ram_rdata (w_ram_rdata),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_char      (m_axis_tdata),
        .o_last      (m_axis_tlast)
    );

endmodule

### sv/ihex_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the Intel HEX record encoder, bound to the top level.
// Depends on ihex_pkg for character codes.

module ihex_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast
);

    // Stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tlast))
        else $error("output word changed while stalled");

    // Reset drops the output word
    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // Every run ends on a line feed
    a_last_lf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata == ihex_pkg::CH_LF)
        else $error("run end not on line feed");

    // Only colon, uppercase hex digits and line feed are ever sent
    a_charset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            (m_axis_tdata == ihex_pkg::CH_COLON) || (m_axis_tdata == ihex_pkg::CH_LF)
            || ((m_axis_tdata >= ihex_pkg::CH_ZERO) && (m_axis_tdata <= ihex_pkg::CH_NINE))
            || ((m_axis_tdata >= ihex_pkg::CH_A) && (m_axis_tdata <= ihex_pkg::CH_F)))
        else $error("character outside HEX text set");

    // After an accepted line feed the output is idle or opens the next line with a colon
    a_colon_after_lf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && (m_axis_tdata == ihex_pkg::CH_LF)
            |=> !m_axis_tvalid || (m_axis_tdata == ihex_pkg::CH_COLON))
        else $error("line does not open with colon");

endmodule

bind intel_hex_record_encoder ihex_checker u_ihex_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
